// File: hw/rtl/mnh32_pkg.sv
// Shared types and constants for the MurmurHash2 neutral 32-bit hash engine.
package mnh32_pkg;

  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int          WORD_SHIFT  = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;

  // Datapath operations, one per cycle.
  typedef enum logic [2:0] {
    DP_NONE,
    DP_LOAD,
    DP_K1,
    DP_K2,
    DP_HM,
    DP_TM,
    DP_AV
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_full;
    logic in_tail;
    logic in_last;
    logic st_last;
    logic out_free;
  } dp_stat_t;

  // Keep only the valid low bytes of a tail word.
  function automatic logic [31:0] tail_mask(input logic [2:0] count);
    logic [31:0] m;
    case (count)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'h0000_00ff;
      3'd2:    m = 32'h0000_ffff;
      3'd3:    m = 32'h00ff_ffff;
      default: m = 32'hffff_ffff;
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/mnh32_dpath.sv
// Datapath: hash and word registers, one shared 32x32 multiplier, result register.
module mnh32_dpath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [mnh32_pkg::IN_TDATA_W-1:0]   s_tdata,
  input  logic                               s_tuser,
  input  logic                               s_tlast,
  input  logic                               cfg_we,
  input  logic [31:0]                        cfg_wdata,
  input  logic                               m_tready,
  input  mnh32_pkg::dp_cmd_t                 cmd,
  output mnh32_pkg::dp_stat_t                stat,
  output logic                               m_tvalid,
  output logic [mnh32_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import mnh32_pkg::*;

  logic [31:0] in_word;
  logic [2:0]  in_count;
  logic [31:0] in_len;

  logic [31:0] seed;
  logic [31:0] h_reg;
  logic [31:0] k_reg;
  logic        last_reg;
  logic        out_valid;
  logic [31:0] out_data;

  logic [31:0] mul_a;
  logic [31:0] prod;

  assign in_word  = s_tdata[31:0];
  assign in_count = s_tdata[34:32];
  assign in_len   = s_tdata[66:35];

  assign stat.in_full  = in_count[2];
  assign stat.in_tail  = !in_count[2] && (in_count[1:0] != 2'd0);
  assign stat.in_last  = s_tlast;
  assign stat.st_last  = last_reg;
  assign stat.out_free = !out_valid || m_tready;

  always_comb begin
    case (cmd.op)
      DP_HM:   mul_a = h_reg;
      DP_TM:   mul_a = h_reg ^ k_reg;
      DP_AV:   mul_a = h_reg ^ (h_reg >> FIN_SHIFT_A);
      default: mul_a = k_reg;
    endcase
  end

  assign prod = mul_a * MIX_MUL;

  // control state and the running hash
  always_ff @(posedge clk) begin
    if (rst) begin
      seed      <= '0;
      h_reg     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed <= cfg_wdata;
      end
      // a new hash is loaded only when the register is free or being drained
      if (cmd.op == DP_AV) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        DP_LOAD: begin
          if (s_tuser) begin
            h_reg <= seed ^ in_len;
          end
        end
        DP_HM:   h_reg <= prod ^ k_reg;
        DP_TM:   h_reg <= prod;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        k_reg    <= in_word & tail_mask(in_count);
        last_reg <= s_tlast;
      end
      DP_K1:   k_reg <= prod ^ (prod >> WORD_SHIFT);
      DP_K2:   k_reg <= prod;
      DP_AV:   out_data <= prod ^ (prod >> FIN_SHIFT_B);
      default: ;
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// File: hw/rtl/mnh32_ctrl.sv
// Controller: sequences the shared multiplier through the steps of one item.
module mnh32_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  mnh32_pkg::dp_stat_t stat,
  output mnh32_pkg::dp_cmd_t  cmd
);
  import mnh32_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_K1   = 6'b000010,
    ST_K2   = 6'b000100,
    ST_HM   = 6'b001000,
    ST_TM   = 6'b010000,
    ST_AV   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd.op     = DP_NONE;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op = DP_LOAD;
          if (stat.in_full) begin
            state_next = ST_K1;
          end else if (stat.in_tail) begin
            state_next = ST_TM;
          end else if (stat.in_last) begin
            state_next = ST_AV;
          end
        end
      end
      ST_K1: begin
        cmd.op     = DP_K1;
        state_next = ST_K2;
      end
      ST_K2: begin
        cmd.op     = DP_K2;
        state_next = ST_HM;
      end
      ST_HM: begin
        cmd.op     = DP_HM;
        state_next = stat.st_last ? ST_AV : ST_IDLE;
      end
      ST_TM: begin
        cmd.op     = DP_TM;
        state_next = stat.st_last ? ST_AV : ST_IDLE;
      end
      ST_AV: begin
        // hold until the result register can take the hash
        if (stat.out_free) begin
          cmd.op     = DP_AV;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/murmur2_neutral_hash32_top.sv
// Top level of the streaming MurmurHash2 neutral 32-bit hash engine.
//
// Input stream (s_axis): one item carries up to four message bytes.
//   tdata = data_word[31:0], byte_count[34:32], message_length[66:35], zero pad.
//   tuser = first_item (restarts the hash at seed ^ message_length).
//   tlast = last_item (runs the final avalanche and emits one hash).
// Output stream (m_axis): tdata = hash_value[31:0], one item per message.
// Config: cfg_we/cfg_wdata write the hash seed; change it only while idle.
//
// Steps per item, all through the single shared 32x32 multiplier:
//   full word: accept + 3 multiplies
//   1-3 tail bytes: accept + 1 multiply;  no bytes: accept only
//   last item adds the avalanche step, then the hash sits in the output register.
// s_axis_tready is high only while the sequencer is idle.
// If the receiver stalls, the next message can still be hashed; only the
// avalanche step of a following last item waits for the output register.
// Reset clears the seed, the running hash and the output valid.
module murmur2_neutral_hash32_top (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,        // hash_seed
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,     // data_word, byte_count, message_length, pad
  input  logic        s_axis_tuser,     // first_item
  input  logic        s_axis_tlast,     // last_item
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata      // hash_value
);
  import mnh32_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mnh32_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_axis_tvalid),
    .s_tready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mnh32_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .s_tlast   (s_axis_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tready  (m_axis_tready),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_axis_tvalid),
    .m_tdata   (m_axis_tdata)
  );

endmodule

// File: hw/rtl/mnh32_checker.sv
// Port-level checks for the hash engine, bound to the top level.
module mnh32_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [71:0] s_axis_tdata,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);

  logic s_acc;
  logic s_nop;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign s_nop = (s_axis_tdata[34:32] == 3'd0) && !s_axis_tlast;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // any item with work keeps the engine busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_acc && !s_nop |=> !s_axis_tready)
    else $error("input ready while item in progress");

  // an empty non-last item leaves the input ready again in the next cycle
  a_nop: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_nop |=> s_axis_tready)
    else $error("empty item stalled the input");

  // reset leaves no result pending
  a_rst: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind murmur2_neutral_hash32_top mnh32_checker u_mnh32_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
